// ===== rtl/core/jdab_pkg.sv =====
// ----------------------------------------------------------------------------
// jdab_pkg
// Shared types and register codes for the joystick dead zone and buttons core.
// ----------------------------------------------------------------------------
package jdab_pkg;

    localparam int CFG_IDX_W = 3;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_DEAD_INNER    = 3'd0,
        CFG_DEAD_OUTER    = 3'd1,
        CFG_SPAN_GAIN     = 3'd2,
        CFG_RELEASE_LEVEL = 3'd3,
        CFG_TRIGGER_LEVEL = 3'd4
    } cfg_index_t;

    localparam logic [14:0] DEAD_INNER_RST    = 15'd4915;
    localparam logic [14:0] DEAD_OUTER_RST    = 15'd16384;
    localparam logic [15:0] SPAN_GAIN_RST     = 16'd23406;
    localparam logic [14:0] RELEASE_LEVEL_RST = 15'd13107;
    localparam logic [14:0] TRIGGER_LEVEL_RST = 15'd14746;

    typedef struct packed {
        logic signed [15:0] raw_x;
        logic signed [15:0] raw_y;
    } in_beat_t;

    typedef struct packed {
        logic signed [15:0] scaled_x;
        logic signed [15:0] scaled_y;
        logic               press_right;
        logic               press_left;
        logic               press_down;
        logic               press_up;
    } out_beat_t;

    typedef struct packed {
        logic [14:0] dead_inner;
        logic [14:0] dead_outer;
        logic [15:0] span_gain;
        logic [14:0] release_level;
        logic [14:0] trigger_level;
    } cfg_t;

    typedef struct packed {
        logic [15:0] scaled;
        logic        negative;
        logic        over_release;
        logic        at_trigger;
    } axis_t;

endpackage

// ===== rtl/core/jdab_lane.sv =====
// ----------------------------------------------------------------------------
// jdab_lane
// One axis: magnitude, dead zone bounds and gain multiply, then saturation,
// sign and the level compares for the button stage.
// ----------------------------------------------------------------------------
module jdab_lane
    import jdab_pkg::*;
#(
    parameter int unsigned FRACTION_BITS = 14
)
(
    input  logic               clk,
    input  logic               load,
    input  logic signed [15:0] raw,
    input  cfg_t               cfg,
    output axis_t              axis
);

    localparam logic [31:0] One = 32'd1 << FRACTION_BITS;

    logic [15:0] mag;
    logic [15:0] diff;
    logic [31:0] shifted;
    logic [31:0] mag_out;
    logic [31:0] signed_out;

    logic        neg_reg;
    logic        below_reg;
    logic        above_reg;
    logic [31:0] prod_reg;

    always_comb
    begin
        mag  = raw[15] ? (~raw + 16'd1) : raw;
        diff = mag - {1'b0, cfg.dead_inner};
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            neg_reg   <= raw[15];
            below_reg <= (mag < {1'b0, cfg.dead_inner});
            above_reg <= (mag > {1'b0, cfg.dead_outer});
            prod_reg  <= {16'd0, diff} * {16'd0, cfg.span_gain};
        end
    end

    always_comb
    begin
        shifted = prod_reg >> FRACTION_BITS;
        if (below_reg)
        begin
            mag_out = 32'd0;
        end
        else if (above_reg || (shifted > One))
        begin
            mag_out = One;
        end
        else
        begin
            mag_out = shifted;
        end
        signed_out        = neg_reg ? (~mag_out + 32'd1) : mag_out;
        axis.scaled       = signed_out[15:0];
        axis.negative     = neg_reg && (mag_out != 32'd0);
        axis.over_release = mag_out > {17'd0, cfg.release_level};
        axis.at_trigger   = mag_out >= {17'd0, cfg.trigger_level};
    end

endmodule

// ===== rtl/core/jdab_merge.sv =====
// ----------------------------------------------------------------------------
// jdab_merge
// Combines both lanes: per-axis press latches and the output register.
// ----------------------------------------------------------------------------
module jdab_merge
    import jdab_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      lane_valid,
    output logic      lane_ready,
    input  axis_t     ax,
    input  axis_t     ay,
    output logic      out_valid,
    input  logic      out_stall,
    output out_beat_t out_data
);

    logic      load;
    logic      latch_h_reg;
    logic      latch_h_next;
    logic      latch_v_reg;
    logic      latch_v_next;
    logic      fire_h;
    logic      fire_v;
    logic      out_valid_reg;
    logic      out_valid_next;
    out_beat_t out_data_reg;
    out_beat_t out_data_next;

    assign lane_ready = !out_valid_reg || !out_stall;
    assign load       = lane_valid && lane_ready;

    always_comb
    begin
        fire_h       = 1'b0;
        fire_v       = 1'b0;
        latch_h_next = latch_h_reg;
        latch_v_next = latch_v_reg;
        if (!(latch_h_reg && ax.over_release))
        begin
            fire_h       = ax.at_trigger;
            latch_h_next = ax.at_trigger;
        end
        if (!(latch_v_reg && ay.over_release))
        begin
            fire_v       = ay.at_trigger;
            latch_v_next = ay.at_trigger;
        end
        out_data_next.scaled_x    = ax.scaled;
        out_data_next.scaled_y    = ay.scaled;
        out_data_next.press_right = fire_h && !ax.negative;
        out_data_next.press_left  = fire_h && ax.negative;
        out_data_next.press_down  = fire_v && !ay.negative;
        out_data_next.press_up    = fire_v && ay.negative;
        out_valid_next = load || (out_valid_reg && out_stall);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            latch_h_reg   <= 1'b0;
            latch_v_reg   <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
            if (load)
            begin
                latch_h_reg <= latch_h_next;
                latch_v_reg <= latch_v_next;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            out_data_reg <= out_data_next;
        end
    end

    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

`ifndef SYNTH
    a_one_dir_h: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg |-> !(out_data_reg.press_right && out_data_reg.press_left))
        else $error("both horizontal presses set");
    a_one_dir_v: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg |-> !(out_data_reg.press_down && out_data_reg.press_up))
        else $error("both vertical presses set");
    a_press_latches: assert property (@(posedge clk) disable iff (!rst_n)
        load && (out_data_next.press_right || out_data_next.press_left) |=> latch_h_reg)
        else $error("horizontal press without latch");
    a_load_shows: assert property (@(posedge clk) disable iff (!rst_n)
        load |=> out_valid_reg)
        else $error("loaded beat not presented");
`endif

endmodule

// ===== rtl/core/joystick_deadzone_axis_buttons_core.sv =====
// ----------------------------------------------------------------------------
// joystick_deadzone_axis_buttons_core
// Two-axis dead zone with gain rescale and latched virtual direction buttons.
// ----------------------------------------------------------------------------
// Each input beat is registered in the lane stage, then in the merge output register.
// Throughput: 1 beat per cycle while out_stall does not hold the output register.
// An output beat held by stall leaves one input beat in flight before stall.
// Reset clears the latches, the valid flags and restores register defaults.
// ----------------------------------------------------------------------------
module joystick_deadzone_axis_buttons_core
    import jdab_pkg::*;
#(
    parameter int unsigned FRACTION_BITS = 14
)
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 in_valid,
    output logic                 in_stall,
    input  in_beat_t             in_data,
    output logic                 out_valid,
    input  logic                 out_stall,
    output out_beat_t            out_data,
    input  logic                 cfg_valid,
    output logic                 cfg_ready,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [15:0]          cfg_data
);

    cfg_t  cfg_reg;
    logic  s1_valid_reg;
    logic  s1_valid_next;
    logic  lane_ready;
    logic  load;
    axis_t ax;
    axis_t ay;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.dead_inner    <= DEAD_INNER_RST;
            cfg_reg.dead_outer    <= DEAD_OUTER_RST;
            cfg_reg.span_gain     <= SPAN_GAIN_RST;
            cfg_reg.release_level <= RELEASE_LEVEL_RST;
            cfg_reg.trigger_level <= TRIGGER_LEVEL_RST;
        end
        else if (cfg_valid && cfg_ready)
        begin
            unique case (cfg_index)
                CFG_DEAD_INNER:    cfg_reg.dead_inner    <= cfg_data[14:0];
                CFG_DEAD_OUTER:    cfg_reg.dead_outer    <= cfg_data[14:0];
                CFG_SPAN_GAIN:     cfg_reg.span_gain     <= cfg_data;
                CFG_RELEASE_LEVEL: cfg_reg.release_level <= cfg_data[14:0];
                CFG_TRIGGER_LEVEL: cfg_reg.trigger_level <= cfg_data[14:0];
                default:           ;
            endcase
        end
    end

    assign in_stall      = s1_valid_reg && !lane_ready;
    assign load          = in_valid && !in_stall;
    assign s1_valid_next = load || (s1_valid_reg && !lane_ready);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
        end
        else
        begin
            s1_valid_reg <= s1_valid_next;
        end
    end

    jdab_lane #(
        .FRACTION_BITS(FRACTION_BITS)
    ) u_lane_x (
        .clk  (clk),
        .load (load),
        .raw  (in_data.raw_x),
        .cfg  (cfg_reg),
        .axis (ax)
    );

    jdab_lane #(
        .FRACTION_BITS(FRACTION_BITS)
    ) u_lane_y (
        .clk  (clk),
        .load (load),
        .raw  (in_data.raw_y),
        .cfg  (cfg_reg),
        .axis (ay)
    );

    jdab_merge u_merge (
        .clk        (clk),
        .rst_n      (rst_n),
        .lane_valid (s1_valid_reg),
        .lane_ready (lane_ready),
        .ax         (ax),
        .ay         (ay),
        .out_valid  (out_valid),
        .out_stall  (out_stall),
        .out_data   (out_data)
    );

endmodule
